FILE: rtl/core/ehgk_pkg.sv
// Shared constants, register codes and helpers for the halfspace Green's kernel core.
`timescale 1ns / 1ps
package ehgk_pkg;

  localparam int YOUNG_W = 10;
  localparam int POIS_W  = 15;
  localparam int DEPTH_W = 20;
  localparam int GRID_W  = 16;
  localparam int QUAD_W  = 3;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 20;

  localparam logic [CFG_AW-1:0] REG_YOUNG = 2'd0;
  localparam logic [CFG_AW-1:0] REG_POIS  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_DEPTH = 2'd2;
  localparam logic [CFG_AW-1:0] REG_GRID  = 2'd3;

  localparam logic [QUAD_W-1:0] QUAD_2 = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_3 = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_4 = 3'd4;

  // 2^78 / (2 pi 10^9)
  localparam logic [45:0] K_SCALE = 46'd48101630005777;
  localparam int K_W     = 63;
  localparam int RATIO_QB = 34;
  localparam int BIG_QB   = 51;

  function automatic logic [32:0] ratio_clamp(input logic [RATIO_QB-1:0] q);
    logic [32:0] r;
    if (q > RATIO_QB'(34'h1_0000_0000)) begin
      r = 33'h1_0000_0000;
    end else begin
      r = q[32:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/ehgk_digit_pipe.sv
// Pipelined one-bit-per-stage restoring divider or square root with sideband.
`timescale 1ns / 1ps
module ehgk_digit_pipe #(
  parameter int W_N     = 64,
  parameter int W_D     = 32,
  parameter int QB      = 32,
  parameter bit IS_SQRT = 1'b0,
  parameter int W_P     = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [W_N-1:0] num_i,
  input  logic [W_D-1:0] den_i,
  input  logic [W_P-1:0] side_i,
  output logic           valid_o,
  output logic [QB-1:0]  quot_o,
  output logic [W_P-1:0] side_o
);

  localparam int CW0 = (W_N > W_D + QB) ? W_N : W_D + QB;
  localparam int CW  = (CW0 > 2 * QB + 1) ? CW0 : 2 * QB + 1;

  logic [CW-1:0]  rem_s  [0:QB];
  logic [QB-1:0]  q_s    [0:QB];
  logic [W_D-1:0] den_s  [0:QB];
  logic [W_P-1:0] side_s [0:QB];
  logic           vld_s  [0:QB];

  assign rem_s[0]  = CW'(num_i);
  assign q_s[0]    = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;
  assign vld_s[0]  = valid_i;

  for (genvar gi = 0; gi < QB; gi++) begin : g_stage
    localparam int B = QB - 1 - gi;
    logic [CW-1:0] trial;
    logic          ge;

    always_comb begin
      if (IS_SQRT) begin
        trial = (CW'(q_s[gi]) << (B + 1)) | (CW'(1) << (2 * B));
      end else begin
        trial = CW'(den_s[gi]) << B;
      end
      ge = rem_s[gi] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[gi+1] <= 1'b0;
      end else if (en_i) begin
        vld_s[gi+1] <= vld_s[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[gi+1]  <= ge ? rem_s[gi] - trial : rem_s[gi];
        q_s[gi+1]    <= q_s[gi] | (QB'(ge) << B);
        den_s[gi+1]  <= den_s[gi];
        side_s[gi+1] <= side_s[gi];
      end
    end
  end

  assign valid_o = vld_s[QB];
  assign quot_o  = q_s[QB];
  assign side_o  = side_s[QB];

endmodule

FILE: rtl/core/elastic_halfspace_green_kernel_core.sv
// Top level: pipelined point-load Green's kernel of an elastic halfspace.
//
//  channel | dir | handshake                     | payload (low bit up)
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: x_index, y_index; tuser: quadrant
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: disp_x, disp_y, disp_z
//  cfg     | in  | cfg_valid_i / cfg_ready_o     | cfg_addr_i: register, cfg_data_i: value
//
// One beat per cycle while m_axis does not stall and no load constant rebuild runs; the
// depth is set by the two square-root pipelines and the 34- and 51-stage divider pipelines.
// After reset and after each write of the modulus or Poisson ratio the load constant
// is rebuilt serially (multiply, then divide); s_axis_tready stays low meanwhile.
// The whole pipeline stalls together while a result waits on m_axis.
`timescale 1ns / 1ps
module elastic_halfspace_green_kernel_core #(
  parameter int INDEX_WIDTH  = 16,
  parameter int RESULT_WIDTH = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_index, y_index
  input  logic [((2*INDEX_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // quadrant
  input  logic [ehgk_pkg::QUAD_W-1:0]           s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // disp_x, disp_y, disp_z
  output logic [((3*RESULT_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ehgk_pkg::CFG_AW-1:0]           cfg_addr_i,
  input  logic [ehgk_pkg::CFG_DW-1:0]           cfg_data_i
);
  import ehgk_pkg::*;

  localparam int IW    = INDEX_WIDTH;
  localparam int RW    = RESULT_WIDTH;
  localparam int ODW   = ((3 * RW + 7) / 8) * 8;
  localparam int W_AX  = IW + 16;
  localparam int W_R2  = 2 * W_AX + 2;
  localparam int W_RAD = W_R2 + 40;
  localparam int W_SQ  = (W_RAD + 1) / 2;
  localparam int W_RQD = W_SQ + 1;
  localparam int W_S1  = 2 * W_AX + QUAD_W + 1;
  localparam int W_S2  = W_SQ + QUAD_W + 1;
  localparam int W_S3  = 33 + 33 + QUAD_W + 2;
  localparam logic [64:0] MAXP = (65'(1) << (RW - 1)) - 65'(1);

  localparam logic [1:0] K_IDLE = 2'd0;
  localparam logic [1:0] K_MUL  = 2'd1;
  localparam logic [1:0] K_DIV  = 2'd2;

  // configuration registers
  logic [YOUNG_W-1:0] young_q;
  logic [POIS_W-1:0]  pois_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [GRID_W-1:0]  grid_q;
  logic               cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      young_q <= 10'd50;
      pois_q  <= 15'd16384;
      depth_q <= '0;
      grid_q  <= 16'd1000;
    end else if (cfg_fire) begin
      case (cfg_addr_i)
        REG_YOUNG: young_q <= cfg_data_i[YOUNG_W-1:0];
        REG_POIS:  pois_q  <= cfg_data_i[POIS_W-1:0];
        REG_DEPTH: depth_q <= cfg_data_i[DEPTH_W-1:0];
        REG_GRID:  grid_q  <= cfg_data_i[GRID_W-1:0];
        default:   young_q <= young_q;
      endcase
    end
  end

  // serial build of k = (65536 + p) * K_SCALE / e
  logic [1:0]         kst_q;
  logic [5:0]         kcnt_q;
  logic [K_W-1:0]     kacc_q;
  logic [YOUNG_W-1:0] krem_q;
  logic [YOUNG_W-1:0] kdiv;
  logic [YOUNG_W:0]   krem_n;
  logic               kge;
  logic               krestart;
  logic               k_rdy;

  assign kdiv     = (young_q == '0) ? YOUNG_W'(1) : young_q;
  assign krem_n   = {krem_q, kacc_q[K_W-1]};
  assign kge      = krem_n >= (YOUNG_W + 1)'(kdiv);
  assign krestart = cfg_fire && (cfg_addr_i == REG_YOUNG || cfg_addr_i == REG_POIS);
  assign k_rdy    = (kst_q == K_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kst_q  <= K_MUL;
      kcnt_q <= '0;
      kacc_q <= K_W'(K_SCALE) << 16;
      krem_q <= '0;
    end else if (krestart) begin
      kst_q  <= K_MUL;
      kcnt_q <= '0;
      kacc_q <= K_W'(K_SCALE) << 16;
      krem_q <= '0;
    end else begin
      case (kst_q)
        K_MUL: begin
          if (pois_q[kcnt_q[3:0]]) begin
            kacc_q <= kacc_q + (K_W'(K_SCALE) << kcnt_q[3:0]);
          end
          if (kcnt_q == 6'd14) begin
            kst_q  <= K_DIV;
            kcnt_q <= '0;
          end else begin
            kcnt_q <= kcnt_q + 6'd1;
          end
        end
        K_DIV: begin
          krem_q <= kge ? YOUNG_W'(krem_n - (YOUNG_W + 1)'(kdiv)) : krem_n[YOUNG_W-1:0];
          kacc_q <= {kacc_q[K_W-2:0], kge};
          if (kcnt_q == 6'd62) begin
            kst_q <= K_IDLE;
          end else begin
            kcnt_q <= kcnt_q + 6'd1;
          end
        end
        default: kst_q <= K_IDLE;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic m_valid_q;
  logic in_fire;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en && k_rdy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // stage 0: magnitudes
  logic [IW-1:0] x_in, y_in, mx_c, my_c;
  logic [IW-1:0] mx0_q, my0_q;
  logic [QUAD_W-1:0] quad0_q;
  logic v0_q;

  assign x_in = s_axis_tdata[IW-1:0];
  assign y_in = s_axis_tdata[2*IW-1:IW];
  assign mx_c = x_in[IW-1] ? (~x_in) + IW'(1) : x_in;
  assign my_c = y_in[IW-1] ? (~y_in) + IW'(1) : y_in;

  // stage 1: scale by spacing
  logic [W_AX-1:0] ax1_q, ay1_q;
  logic [QUAD_W-1:0] quad1_q;
  logic v1_q;

  // stage 2: partial squares
  logic [W_AX+15:0] sqxl2_q, sqyl2_q;
  logic [W_AX+IW-1:0] sqxh2_q, sqyh2_q;
  logic [W_AX-1:0] ax2_q, ay2_q;
  logic [QUAD_W-1:0] quad2_q;
  logic zero2_q, v2_q;

  // stage 3: squares
  logic [2*W_AX-1:0] sqx3_q, sqy3_q;
  logic [W_AX-1:0] ax3_q, ay3_q;
  logic [QUAD_W-1:0] quad3_q;
  logic zero3_q, v3_q;

  // stage 4: r^2 and R^2
  logic [39:0] dd;
  logic [W_R2-1:0] r2_4_q, rr2_4_q;
  logic [W_AX-1:0] ax4_q, ay4_q;
  logic [QUAD_W-1:0] quad4_q;
  logic zero4_q, v4_q;

  assign dd = 40'(depth_q) * 40'(depth_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_fire;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx0_q   <= mx_c;
      my0_q   <= my_c;
      quad0_q <= s_axis_tuser;
      ax1_q   <= W_AX'(mx0_q) * W_AX'(grid_q);
      ay1_q   <= W_AX'(my0_q) * W_AX'(grid_q);
      quad1_q <= quad0_q;
      sqxl2_q <= (W_AX + 16)'(ax1_q) * (W_AX + 16)'(ax1_q[15:0]);
      sqyl2_q <= (W_AX + 16)'(ay1_q) * (W_AX + 16)'(ay1_q[15:0]);
      sqxh2_q <= (W_AX + IW)'(ax1_q) * (W_AX + IW)'(ax1_q[W_AX-1:16]);
      sqyh2_q <= (W_AX + IW)'(ay1_q) * (W_AX + IW)'(ay1_q[W_AX-1:16]);
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      quad2_q <= quad1_q;
      zero2_q <= (ax1_q == '0) && (ay1_q == '0);
      sqx3_q  <= (2 * W_AX)'(sqxl2_q) + ((2 * W_AX)'(sqxh2_q) << 16);
      sqy3_q  <= (2 * W_AX)'(sqyl2_q) + ((2 * W_AX)'(sqyh2_q) << 16);
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      quad3_q <= quad2_q;
      zero3_q <= zero2_q;
      r2_4_q  <= W_R2'(sqx3_q) + W_R2'(sqy3_q);
      rr2_4_q <= W_R2'(sqx3_q) + W_R2'(sqy3_q) + W_R2'(dd);
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
      quad4_q <= quad3_q;
      zero4_q <= zero3_q;
    end
  end

  // square roots, Q20
  logic [W_SQ-1:0] rq_s, rrq_s;
  logic [W_S1-1:0] s1;
  logic            vs1;
  logic [W_AX-1:0] s1_ax, s1_ay;
  logic [QUAD_W-1:0] s1_quad;
  logic            s1_zero;

  ehgk_digit_pipe #(
    .W_N(W_RAD), .W_D(1), .QB(W_SQ), .IS_SQRT(1'b1), .W_P(W_S1)
  ) u_sqrt_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q),
    .num_i({r2_4_q, 40'b0}), .den_i(1'b0),
    .side_i({ax4_q, ay4_q, quad4_q, zero4_q}),
    .valid_o(vs1), .quot_o(rq_s), .side_o(s1)
  );

  ehgk_digit_pipe #(
    .W_N(W_RAD), .W_D(1), .QB(W_SQ), .IS_SQRT(1'b1), .W_P(1)
  ) u_sqrt_rr (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q),
    .num_i({rr2_4_q, 40'b0}), .den_i(1'b0), .side_i(1'b0),
    .valid_o(), .quot_o(rrq_s), .side_o()
  );

  assign {s1_ax, s1_ay, s1_quad, s1_zero} = s1;

  // stage 5
  logic [W_SQ-1:0] rq5_q, rrq5_q;
  logic [W_RQD-1:0] rqd5_q;
  logic [W_AX-1:0] ax5_q, ay5_q;
  logic [QUAD_W-1:0] quad5_q;
  logic zero5_q, v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= vs1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rq5_q   <= rq_s;
      rrq5_q  <= rrq_s;
      rqd5_q  <= W_RQD'(rrq_s) + W_RQD'({depth_q, 20'b0});
      ax5_q   <= s1_ax;
      ay5_q   <= s1_ay;
      quad5_q <= s1_quad;
      zero5_q <= s1_zero;
    end
  end

  // Q32 ratios
  logic [RATIO_QB-1:0] qa, qb, qt, qcx, qcy;
  logic [W_S2-1:0] s2;
  logic            vs2;
  logic [W_SQ-1:0] s2_rrq;
  logic [QUAD_W-1:0] s2_quad;
  logic            s2_zero;

  ehgk_digit_pipe #(
    .W_N(W_SQ + 32), .W_D(W_SQ), .QB(RATIO_QB), .IS_SQRT(1'b0), .W_P(W_S2)
  ) u_div_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q),
    .num_i({rq5_q, 32'b0}), .den_i(rrq5_q), .side_i({rrq5_q, quad5_q, zero5_q}),
    .valid_o(vs2), .quot_o(qa), .side_o(s2)
  );

  ehgk_digit_pipe #(
    .W_N(DEPTH_W + 52), .W_D(W_SQ), .QB(RATIO_QB), .IS_SQRT(1'b0), .W_P(1)
  ) u_div_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q),
    .num_i({depth_q, 52'b0}), .den_i(rrq5_q), .side_i(1'b0),
    .valid_o(), .quot_o(qb), .side_o()
  );

  ehgk_digit_pipe #(
    .W_N(W_SQ + 32), .W_D(W_RQD), .QB(RATIO_QB), .IS_SQRT(1'b0), .W_P(1)
  ) u_div_t (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q),
    .num_i({rq5_q, 32'b0}), .den_i(rqd5_q), .side_i(1'b0),
    .valid_o(), .quot_o(qt), .side_o()
  );

  ehgk_digit_pipe #(
    .W_N(W_AX + 52), .W_D(W_SQ), .QB(RATIO_QB), .IS_SQRT(1'b0), .W_P(1)
  ) u_div_cx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q),
    .num_i({ax5_q, 52'b0}), .den_i(rq5_q), .side_i(1'b0),
    .valid_o(), .quot_o(qcx), .side_o()
  );

  ehgk_digit_pipe #(
    .W_N(W_AX + 52), .W_D(W_SQ), .QB(RATIO_QB), .IS_SQRT(1'b0), .W_P(1)
  ) u_div_cy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q),
    .num_i({ay5_q, 52'b0}), .den_i(rq5_q), .side_i(1'b0),
    .valid_o(), .quot_o(qcy), .side_o()
  );

  assign {s2_rrq, s2_quad, s2_zero} = s2;

  // stages 6 to 9: bracket terms and k products
  logic [32:0] a_c, b_c, t_c;
  logic [16:0] nu2_f, nu1_f;
  logic [65:0] bb6_q, ab6_q;
  logic [49:0] t16_q;
  logic [32:0] cx6_q, cy6_q, cx7_q, cy7_q, cx8_q, cy8_q, cx9_q, cy9_q;
  logic [W_SQ-1:0] rrq6_q, rrq7_q, rrq8_q, rrq9_q;
  logic [QUAD_W-1:0] quad6_q, quad7_q, quad8_q, quad9_q;
  logic zero6_q, zero7_q, zero8_q, zero9_q;
  logic v6_q, v7_q, v8_q, v9_q;
  logic [33:0] t1, t2;
  logic [33:0] bz7_q, brmag7_q;
  logic brpos7_q, brpos8_q, brpos9_q;
  logic [65:0] pzl8_q, prl8_q;
  logic [64:0] pzh8_q, prh8_q;
  logic [96:0] mn9_q, hn9_q;

  assign a_c   = ratio_clamp(qa);
  assign b_c   = ratio_clamp(qb);
  assign t_c   = ratio_clamp(qt);
  assign nu2_f = 17'h10000 - {1'b0, pois_q, 1'b0};
  assign nu1_f = 17'h10000 - {2'b0, pois_q};
  assign t1    = t16_q[49:16];
  assign t2    = ab6_q[65:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v6_q <= vs2;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bb6_q    <= 66'(b_c) * 66'(b_c);
      ab6_q    <= 66'(a_c) * 66'(b_c);
      t16_q    <= 50'(nu2_f) * 50'(t_c);
      cx6_q    <= ratio_clamp(qcx);
      cy6_q    <= ratio_clamp(qcy);
      rrq6_q   <= s2_rrq;
      quad6_q  <= s2_quad;
      zero6_q  <= s2_zero;
      bz7_q    <= {nu1_f, 17'b0} + bb6_q[65:32];
      brpos7_q <= t1 > t2;
      brmag7_q <= (t1 > t2) ? t1 - t2 : t2 - t1;
      cx7_q    <= cx6_q;
      cy7_q    <= cy6_q;
      rrq7_q   <= rrq6_q;
      quad7_q  <= quad6_q;
      zero7_q  <= zero6_q;
      pzl8_q   <= 66'(kacc_q[31:0]) * 66'(bz7_q);
      pzh8_q   <= 65'(kacc_q[K_W-1:32]) * 65'(bz7_q);
      prl8_q   <= 66'(kacc_q[31:0]) * 66'(brmag7_q);
      prh8_q   <= 65'(kacc_q[K_W-1:32]) * 65'(brmag7_q);
      brpos8_q <= brpos7_q;
      cx8_q    <= cx7_q;
      cy8_q    <= cy7_q;
      rrq8_q   <= rrq7_q;
      quad8_q  <= quad7_q;
      zero8_q  <= zero7_q;
      mn9_q    <= 97'(pzl8_q) + (97'(pzh8_q) << 32);
      hn9_q    <= 97'(prl8_q) + (97'(prh8_q) << 32);
      brpos9_q <= brpos8_q;
      cx9_q    <= cx8_q;
      cy9_q    <= cy8_q;
      rrq9_q   <= rrq8_q;
      quad9_q  <= quad8_q;
      zero9_q  <= zero8_q;
    end
  end

  // divide by R, with the 2^26 scale folded into the divisor
  logic [BIG_QB-1:0] mz_s, hr_s;
  logic [W_S3-1:0] s3;
  logic vs3;
  logic [32:0] s3_cx, s3_cy;
  logic [QUAD_W-1:0] s3_quad;
  logic s3_zero, s3_brpos;

  ehgk_digit_pipe #(
    .W_N(97), .W_D(W_SQ + 26), .QB(BIG_QB), .IS_SQRT(1'b0), .W_P(W_S3)
  ) u_div_z (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v9_q),
    .num_i(mn9_q), .den_i({rrq9_q, 26'b0}),
    .side_i({cx9_q, cy9_q, quad9_q, zero9_q, brpos9_q}),
    .valid_o(vs3), .quot_o(mz_s), .side_o(s3)
  );

  ehgk_digit_pipe #(
    .W_N(97), .W_D(W_SQ + 26), .QB(BIG_QB), .IS_SQRT(1'b0), .W_P(1)
  ) u_div_h (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v9_q),
    .num_i(hn9_q), .den_i({rrq9_q, 26'b0}), .side_i(1'b0),
    .valid_o(), .quot_o(hr_s), .side_o()
  );

  assign {s3_cx, s3_cy, s3_quad, s3_zero, s3_brpos} = s3;

  // stages 10, 11: horizontal split
  logic [64:0] hxl10_q, hyl10_q;
  logic [51:0] hxh10_q, hyh10_q;
  logic [BIG_QB-1:0] mz10_q, mz11_q;
  logic negx10_q, negy10_q, zero10_q, v10_q;
  logic [83:0] sumx, sumy;
  logic [51:0] dx11_q, dy11_q;
  logic negx11_q, negy11_q, zero11_q, v11_q;

  assign sumx = 84'(hxl10_q) + (84'(hxh10_q) << 32);
  assign sumy = 84'(hyl10_q) + (84'(hyh10_q) << 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else if (en) begin
      v10_q <= vs3;
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hxl10_q  <= 65'(hr_s[31:0]) * 65'(s3_cx);
      hyl10_q  <= 65'(hr_s[31:0]) * 65'(s3_cy);
      hxh10_q  <= 52'(hr_s[BIG_QB-1:32]) * 52'(s3_cx);
      hyh10_q  <= 52'(hr_s[BIG_QB-1:32]) * 52'(s3_cy);
      mz10_q   <= mz_s;
      negx10_q <= s3_brpos != (s3_quad == QUAD_3 || s3_quad == QUAD_4);
      negy10_q <= s3_brpos != (s3_quad == QUAD_2 || s3_quad == QUAD_3);
      zero10_q <= s3_zero;
      dx11_q   <= sumx[83:32];
      dy11_q   <= sumy[83:32];
      mz11_q   <= mz10_q;
      negx11_q <= negx10_q;
      negy11_q <= negy10_q;
      zero11_q <= zero10_q;
    end
  end

  // output register with saturation
  function automatic logic [RW-1:0] sat(input logic [51:0] mag, input logic neg);
    logic [64:0] m;
    logic [64:0] v;
    m = 65'(mag);
    if (neg) begin
      if (m > MAXP + 65'(1)) begin
        m = MAXP + 65'(1);
      end
      v = 65'(0) - m;
    end else begin
      if (m > MAXP) begin
        m = MAXP;
      end
      v = m;
    end
    return v[RW-1:0];
  endfunction

  logic [ODW-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zero11_q) begin
        m_data_q <= '0;
      end else begin
        m_data_q <= ODW'({sat(52'(mz11_q), 1'b1), sat(dy11_q, negy11_q),
                          sat(dx11_q, negx11_q)});
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the halfspace Green's kernel core.
`timescale 1ns / 1ps
module testbench;
  import ehgk_pkg::*;

  localparam int IW = 16;
  localparam int RW = 48;
  localparam int DRAIN_CYCLES = 260;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [QUAD_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  logic [YOUNG_W-1:0] young_cfg;
  logic [POIS_W-1:0] pois_cfg;
  logic [DEPTH_W-1:0] depth_cfg;
  logic [GRID_W-1:0] grid_cfg;

  logic [143:0] disp_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  int hold_cycles = 0;

  elastic_halfspace_green_kernel_core #(.INDEX_WIDTH(IW), .RESULT_WIDTH(RW)) u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] isqrt(input logic [127:0] n);
    logic [127:0] res, c;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      c = res | (128'd1 << i);
      if (c * c <= n) res = c;
    end
    return res[63:0];
  endfunction

  function automatic logic [63:0] ratio_q32(input logic [127:0] num, input logic [127:0] den);
    logic [127:0] q;
    q = num / den;
    if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
    return q[63:0];
  endfunction

  function automatic logic [63:0] mul_hi32(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] w;
    w = ({64'd0, a} * {64'd0, b}) >> 32;
    return w[63:0];
  endfunction

  function automatic logic [RW-1:0] clip(input logic [63:0] mag, input bit neg);
    logic [63:0] lim, v;
    lim = (64'd1 << (RW - 1)) - 1;
    if (neg) begin
      if (mag > lim + 1) mag = lim + 1;
      v = 64'd0 - mag;
    end else begin
      if (mag > lim) mag = lim;
      v = mag;
    end
    return v[RW-1:0];
  endfunction

  function automatic logic [63:0] idx_mag(input logic [IW-1:0] v);
    logic [63:0] m;
    m = v[IW-1] ? (64'd1 << IW) - {48'd0, v} : {48'd0, v};
    return m;
  endfunction

  function automatic logic [143:0] green_kernel(input logic [IW-1:0] xi, input logic [IW-1:0] yi,
                                                input logic [QUAD_W-1:0] quad);
    logic [127:0] ax, ay, r2, rq, big_r, dq, d, a, b, t, cx, cy, k, bz, t1, t2, brmag, mz, hr;
    logic [127:0] e, p;
    bit brpos, negx, negy;
    ax = 128'(idx_mag(xi)) * 128'(grid_cfg);
    ay = 128'(idx_mag(yi)) * 128'(grid_cfg);
    p = 128'(pois_cfg);
    e = (young_cfg == 0) ? 128'd1 : 128'(young_cfg);
    d = 128'(depth_cfg);
    dq = d << 20;
    r2 = ax * ax + ay * ay;
    if (r2 == 0) return '0;
    rq = 128'(isqrt(r2 << 40));
    big_r = 128'(isqrt((r2 + d * d) << 40));
    a = 128'(ratio_q32(rq << 32, big_r));
    b = 128'(ratio_q32(dq << 32, big_r));
    t = 128'(ratio_q32(rq << 32, big_r + dq));
    cx = 128'(ratio_q32(ax << 52, rq));
    cy = 128'(ratio_q32(ay << 52, rq));
    k = ((65536 + p) * K_SCALE) / e;
    bz = (((65536 - p) << 17) + 128'(mul_hi32(b[63:0], b[63:0]))) &
         128'hffff_ffff_ffff_ffff;
    t1 = (((65536 - 2 * p) * t) >> 16) & 128'hffff_ffff_ffff_ffff;
    t2 = 128'(mul_hi32(a[63:0], b[63:0]));
    brpos = t1 > t2;
    brmag = brpos ? t1 - t2 : t2 - t1;
    mz = ((k * bz) / big_r) >> 26;
    hr = ((k * brmag) / big_r) >> 26;
    negx = brpos != (quad == QUAD_3 || quad == QUAD_4);
    negy = brpos != (quad == QUAD_2 || quad == QUAD_3);
    return {clip(mz[63:0], 1'b1),
            clip(mul_hi32(hr[63:0], cy[63:0]), negy),
            clip(mul_hi32(hr[63:0], cx[63:0]), negx)};
  endfunction

  // result checker
  always @(posedge clk_i) begin
    logic [143:0] exp_v;
    if (m_axis_tvalid && m_axis_tready) begin
      if (disp_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_v = disp_q.pop_front();
        for (int f = 0; f < 3; f++) begin
          if (m_axis_tdata[f*48 +: 48] !== exp_v[f*48 +: 48]) begin
            $display("%0t: field %0d expected %h actual %h", $time, f,
                     exp_v[f*48 +: 48], m_axis_tdata[f*48 +: 48]);
            errors++;
          end
        end
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  task automatic send_point(input logic [IW-1:0] xi, input logic [IW-1:0] yi,
                            input logic [QUAD_W-1:0] quad);
    while (!quiet && $urandom_range(99) < 23) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {yi, xi};
    s_axis_tuser = quad;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    disp_q.push_back(green_kernel(xi, yi, quad));
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid = 1'b0;
    while (disp_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_addr_i = addr;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (addr)
      REG_YOUNG: young_cfg = val[YOUNG_W-1:0];
      REG_POIS:  pois_cfg = val[POIS_W-1:0];
      REG_DEPTH: depth_cfg = val[DEPTH_W-1:0];
      default:   grid_cfg = val[GRID_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_params(input int ym, input int pr, input int dm, input int gs);
    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    write_reg(REG_YOUNG, CFG_DW'(ym));
    write_reg(REG_POIS, CFG_DW'(pr));
    write_reg(REG_DEPTH, CFG_DW'(dm));
    write_reg(REG_GRID, CFG_DW'(gs));
  endtask

  function automatic logic [IW-1:0] rand_index();
    case ($urandom_range(3))
      0: return IW'($urandom_range(7));
      1: return IW'(-$urandom_range(7));
      2: return IW'($urandom_range(300) - 150);
      default: return IW'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    logic [IW-1:0] xs[8] = '{16'd0, 16'd1, 16'd0, 16'h8000, 16'h7fff, 16'h8000, 16'hffff, 16'd3};
    logic [IW-1:0] ys[8] = '{16'd0, 16'd0, 16'd1, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 16'hfffc};
    for (int i = 0; i < 8; i++) send_point(xs[i], ys[i], 3'd1);
    for (int q = 0; q < 8; q++) send_point(16'd5, 16'hfff9, QUAD_W'(q));
    set_params(0, 0, 0, 1);
    send_point(16'd1, 16'd0, 3'd1);
    send_point(16'd1, 16'd1, 3'd3);
    set_params(1023, 32767, 1048575, 0);
    send_point(16'd9, 16'd9, 3'd2);
    set_params(1, 32767, 1048575, 65535);
    send_point(16'h8000, 16'h7fff, 3'd4);
    send_point(16'd1, 16'd0, 3'd1);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_point(rand_index(), rand_index(),
                 QUAD_W'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                  : $urandom_range(4, 1)));
    end
  endtask

  task automatic test_sweep();
    set_params(50, 16384, 0, 1000);
    test_random(150);
    set_params(1023, 0, 1048575, 65535);
    test_random(120);
    set_params(1, 32767, 0, 1);
    test_random(120);
    set_params($urandom_range(1023), $urandom_range(32767), $urandom_range(1048575),
               $urandom_range(65535));
    quiet = 1'b1;
    test_random(150);
    quiet = 1'b0;
    set_params(200, 10000, 5000, 250);
    test_random(150);
    set_params($urandom_range(1023, 1), $urandom_range(32767), $urandom_range(2000),
               $urandom_range(65535, 1));
    test_random(120);
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    test_random(300);
    wait_drain();
    test_random(40);
  endtask

  initial begin
    young_cfg = 50;
    pois_cfg = 16384;
    depth_cfg = 0;
    grid_cfg = 1000;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_sweep();
    test_backpressure();
    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && disp_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ehgk_pkg.sv
rtl/core/ehgk_digit_pipe.sv
rtl/core/elastic_halfspace_green_kernel_core.sv
tb/testbench.sv
